// ===== rtl/core/skc_pkg.sv =====
// ----------------------------------------------------------------------------
// skc_pkg: shared types and constants of the stereo soft-knee clipper
// Register layout, fixed-point constants of the gain and ratio terms, and the
// curve zone code that travels with each sample through a lane.
// ----------------------------------------------------------------------------
`default_nettype none

package skc_pkg;

    localparam int REG_W  = 23;
    localparam int SAT_W  = 16;
    localparam int GAIN_W = SAT_W + 1;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [REG_W-1:0] THRESH_RST = 23'd471859;
    localparam logic [REG_W-1:0] KNEE_RST   = 23'd104858;

    // Drive gain is (GAIN_ONE + u) / GAIN_ONE, ratio is (u + RATIO_BASE) / RATIO_MUL.
    localparam logic [GAIN_W-1:0] GAIN_ONE   = 17'd10240;
    localparam logic [GAIN_W-1:0] GAIN_HALF  = 17'd5120;
    localparam logic [GAIN_W-1:0] RATIO_BASE = 17'd2560;
    localparam logic [GAIN_W-1:0] QUAD_BASE  = 17'd1920;
    localparam logic [GAIN_W-1:0] RATIO_MUL  = 17'd640;

    typedef enum logic {
        REG_THRESH = 1'b0,
        REG_KNEE   = 1'b1
    } t_reg_sel;

    typedef enum logic [1:0] {
        ZONE_LINEAR,
        ZONE_ABOVE,
        ZONE_KNEE
    } t_zone;

    typedef struct packed {
        logic [REG_W-1:0] thresh;
        logic [REG_W-1:0] knee;
    } t_cfg;

endpackage

`default_nettype wire

// ===== rtl/core/skc_in_if.sv =====
// ----------------------------------------------------------------------------
// skc_in_if: input sample channel
// One stereo pair and the saturation amount per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface skc_in_if #(
    parameter int SAMPLE_BITS = 24
) ();
    logic                                valid;
    logic                                ready;
    logic signed [SAMPLE_BITS-1:0]       left_in;
    logic signed [SAMPLE_BITS-1:0]       right_in;
    logic        [skc_pkg::SAT_W-1:0]    saturation;

    modport source (output valid, output left_in, output right_in, output saturation,
                    input ready);
    modport sink   (input valid, input left_in, input right_in, input saturation,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/skc_out_if.sv =====
// ----------------------------------------------------------------------------
// skc_out_if: output sample channel
// One clipped stereo pair per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface skc_out_if #(
    parameter int SAMPLE_BITS = 24
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/skc_div.sv =====
// ----------------------------------------------------------------------------
// skc_div: pipelined restoring divider
// One quotient bit per stage, most significant first. The caller guarantees
// that the quotient fits in QW bits. A side payload rides along each item.
// ----------------------------------------------------------------------------
`default_nettype none

module skc_div #(
    parameter int NW = 48,
    parameter int DW = 17,
    parameter int QW = 26,
    parameter int PW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [PW-1:0] i_pay,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic [PW-1:0] o_pay
);

    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic          r_vld [QW];
    logic [NW-1:0] r_rem [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_quo [QW];
    logic [PW-1:0] r_pay [QW];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic          vld_in;
        logic [NW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic [PW-1:0] pay_in;
        logic [CW-1:0] sub_d;
        logic          take;

        if (j == 0) begin : g_first
            assign vld_in = i_valid;
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
            assign pay_in = i_pay;
        end else begin : g_next
            assign vld_in = r_vld[j-1];
            assign rem_in = r_rem[j-1];
            assign den_in = r_den[j-1];
            assign quo_in = r_quo[j-1];
            assign pay_in = r_pay[j-1];
        end

        assign sub_d = CW'(den_in) << (QW - 1 - j);
        assign take  = CW'(rem_in) >= sub_d;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= take ? NW'(CW'(rem_in) - sub_d) : rem_in;
                r_den[j] <= den_in;
                r_quo[j] <= {quo_in[QW-2:0], take};
                r_pay[j] <= pay_in;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_pay   = r_pay[QW-1];

endmodule

`default_nettype wire

// ===== rtl/core/skc_lane.sv =====
// ----------------------------------------------------------------------------
// skc_lane: one channel of the soft-knee clipper
// Drive, rectify, classify against the knee, evaluate the curve segment and
// restore the sign with saturation. Fully pipelined, frozen by i_en.
// ----------------------------------------------------------------------------
`default_nettype none

module skc_lane #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic signed [SAMPLE_BITS-1:0]   i_sample,
    input  logic        [skc_pkg::SAT_W-1:0] i_sat,
    input  skc_pkg::t_cfg                   i_cfg,
    output logic                            o_valid,
    output logic signed [SAMPLE_BITS-1:0]   o_sample
);

    localparam int SB   = SAMPLE_BITS;
    localparam int RW   = skc_pkg::REG_W;
    localparam int SW   = skc_pkg::SAT_W;
    localparam int GW   = skc_pkg::GAIN_W;
    localparam int N1W  = SB + GW;
    localparam int MW   = SB + 2;
    localparam int DSW  = ((MW > RW) ? MW : RW) + 1;
    localparam int YW   = DSW + 1;
    localparam int NAW  = SB + 12;
    localparam int EW   = RW + 1;
    localparam int N3W  = 2 * EW + 1;
    localparam int KDW  = RW + 3;
    localparam int QW3  = RW;
    localparam int NKW  = QW3 + GW;
    localparam int N4W  = (NAW > NKW) ? NAW : NKW;
    localparam int QW4  = (SB + 1 > QW3) ? SB + 1 : QW3;

    localparam logic signed [YW-1:0] SAT_HI = {{(YW - SB + 1){1'b0}}, {(SB - 1){1'b1}}};
    localparam logic signed [YW-1:0] SAT_LO = ~SAT_HI;

    typedef struct packed {
        logic          neg;
        logic          zero;
        logic [SW-1:0] sat;
    } t_p1;

    typedef struct packed {
        skc_pkg::t_zone zone;
        logic [NAW-1:0] na;
        logic [MW-1:0]  m;
        logic           neg;
        logic           zero;
        logic [SW-1:0]  sat;
    } t_p3;

    typedef struct packed {
        skc_pkg::t_zone zone;
        logic [MW-1:0]  m;
        logic           neg;
        logic           zero;
    } t_p4;

    // Stage 1: rectify and apply the drive gain, with the rounding offset.
    logic          w_neg;
    logic [SB-1:0] w_mag;
    logic [GW-1:0] w_gain;
    logic          r1_vld;
    logic [N1W-1:0] r1_num;
    t_p1           r1_pay;

    assign w_neg  = i_sample[SB-1];
    assign w_mag  = w_neg ? unsigned'(-i_sample) : unsigned'(i_sample);
    assign w_gain = GW'(i_sat) + skc_pkg::GAIN_ONE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_num <= N1W'(w_mag) * N1W'(w_gain) + N1W'(skc_pkg::GAIN_HALF);
            r1_pay <= '{neg: w_neg, zero: (i_sample == '0), sat: i_sat};
        end
    end

    // The gain divisor is 10240 = 2048 * 5. A shift drops the 2048 and a
    // reciprocal multiplication divides by five; with 5 * RECIP5 one above a
    // power of two the quotient is exact for every numerator below 2^KSH.
    localparam int XW   = N1W - 11;
    localparam int KSH  = XW + ((6 - (XW % 4)) % 4);
    localparam int P5W  = XW + KSH;
    localparam logic [KSH-1:0] RECIP5 = KSH'(((longint'(1) <<< KSH) + 1) / 5);

    logic [XW-1:0]  w_n11;
    logic [P5W-1:0] w_p5;
    logic           r1q_vld;
    logic [MW-1:0]  r1q_m;
    t_p1            r1q_pay;
    logic          w1_vld;
    logic [MW-1:0] w1_m;
    t_p1           w1_p;

    assign w_n11 = r1_num[N1W-1:11];
    assign w_p5  = P5W'(w_n11) * P5W'(RECIP5);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1q_vld <= 1'b0;
        end else if (i_en) begin
            r1q_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1q_m   <= w_p5[KSH +: MW];
            r1q_pay <= r1_pay;
        end
    end

    assign w1_vld = r1q_vld;
    assign w1_m   = r1q_m;
    assign w1_p   = r1q_pay;

    // Stage 2: distance from the threshold.
    logic                  r2_vld;
    logic signed [DSW-1:0] r2_d;
    logic        [MW-1:0]  r2_m;
    t_p1                   r2_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (i_en) begin
            r2_vld <= w1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_d <= signed'(DSW'(w1_m)) - signed'(DSW'(i_cfg.thresh));
            r2_m <= w1_m;
            r2_p <= w1_p;
        end
    end

    // Stage 3: pick the curve segment and prepare both numerators.
    logic        [RW-1:0]  w_k;
    logic signed [YW-1:0]  w_d2;
    logic signed [YW-1:0]  w_kk;
    logic signed [YW-1:0]  w_esum;
    logic        [GW-1:0]  w_rhalf3;
    skc_pkg::t_zone        w_zone;
    logic                  r3_vld;
    skc_pkg::t_zone        r3_zone;
    logic        [EW-1:0]  r3_e;
    logic        [NAW-1:0] r3_na;
    logic        [MW-1:0]  r3_m;
    t_p1                   r3_p;

    // A knee width of zero behaves as one LSB.
    assign w_k      = (i_cfg.knee == '0) ? RW'(1) : i_cfg.knee;
    assign w_d2     = {r2_d, 1'b0};
    assign w_kk     = signed'(YW'(w_k));
    assign w_esum   = w_d2 + w_kk;
    assign w_rhalf3 = (GW'(r2_p.sat) + skc_pkg::RATIO_BASE) >> 1;

    always_comb begin
        if (w_d2 < -w_kk) begin
            w_zone = skc_pkg::ZONE_LINEAR;
        end else if (w_d2 > w_kk) begin
            w_zone = skc_pkg::ZONE_ABOVE;
        end else begin
            w_zone = skc_pkg::ZONE_KNEE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_zone <= w_zone;
            r3_e    <= w_esum[EW-1:0];
            r3_na   <= NAW'(unsigned'(r2_d)) * NAW'(skc_pkg::RATIO_MUL) + NAW'(w_rhalf3);
            r3_m    <= r2_m;
            r3_p    <= r2_p;
        end
    end

    // Stage 4: square of the knee offset, plus half of 8K for rounding.
    logic           r4_vld;
    logic [N3W-1:0] r4_num;
    t_p3            r4_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_num <= N3W'(r3_e) * N3W'(r3_e) + (N3W'(w_k) << 2);
            r4_pay <= '{zone: r3_zone, na: r3_na, m: r3_m,
                        neg: r3_p.neg, zero: r3_p.zero, sat: r3_p.sat};
        end
    end

    logic           w3_vld;
    logic [QW3-1:0] w3_t;
    logic [$bits(t_p3)-1:0] w3_pay;
    t_p3            w3_p;

    skc_div #(
        .NW (N3W),
        .DW (KDW),
        .QW (QW3),
        .PW ($bits(t_p3))
    ) u_div_knee (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r4_vld),
        .i_num   (r4_num),
        .i_den   ({w_k, 3'b000}),
        .i_pay   (r4_pay),
        .o_valid (w3_vld),
        .o_quo   (w3_t),
        .o_pay   (w3_pay)
    );

    assign w3_p = w3_pay;

    // Stage 5: the ratio divider is shared by the compressed and the knee segment.
    logic [GW-1:0]  w_den4;
    logic [GW-1:0]  w_rhalf4;
    logic [NKW-1:0] w_nk;
    logic           r5_vld;
    logic [N4W-1:0] r5_num;
    logic [GW-1:0]  r5_den;
    t_p4            r5_pay;

    assign w_den4   = GW'(w3_p.sat) + skc_pkg::RATIO_BASE;
    assign w_rhalf4 = w_den4 >> 1;
    assign w_nk     = NKW'(w3_t) * NKW'(GW'(w3_p.sat) + skc_pkg::QUAD_BASE) + NKW'(w_rhalf4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (i_en) begin
            r5_vld <= w3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_num <= (w3_p.zone == skc_pkg::ZONE_ABOVE) ? N4W'(w3_p.na) : N4W'(w_nk);
            r5_den <= w_den4;
            r5_pay <= '{zone: w3_p.zone, m: w3_p.m, neg: w3_p.neg, zero: w3_p.zero};
        end
    end

    logic           w4_vld;
    logic [QW4-1:0] w4_q;
    logic [$bits(t_p4)-1:0] w4_pay;
    t_p4            w4_p;

    skc_div #(
        .NW (N4W),
        .DW (GW),
        .QW (QW4),
        .PW ($bits(t_p4))
    ) u_div_ratio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r5_vld),
        .i_num   (r5_num),
        .i_den   (r5_den),
        .i_pay   (r5_pay),
        .o_valid (w4_vld),
        .o_quo   (w4_q),
        .o_pay   (w4_pay)
    );

    assign w4_p = w4_pay;

    // Stage 6: curve value of the magnitude.
    logic                 r6_vld;
    logic signed [YW-1:0] r6_y;
    logic                 r6_neg;
    logic                 r6_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (i_en) begin
            r6_vld <= w4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (w4_p.zone)
                skc_pkg::ZONE_ABOVE: begin
                    r6_y <= signed'(YW'(i_cfg.thresh)) + signed'(YW'(w4_q));
                end
                skc_pkg::ZONE_KNEE: begin
                    r6_y <= signed'(YW'(w4_p.m)) - signed'(YW'(w4_q));
                end
                default: begin
                    r6_y <= signed'(YW'(w4_p.m));
                end
            endcase
            r6_neg  <= w4_p.neg;
            r6_zero <= w4_p.zero;
        end
    end

    // Stage 7: restore the sign and saturate. A negative knee value flips the sign.
    logic signed [YW-1:0] w_sv;
    logic signed [SB-1:0] w_out;
    logic                 r7_vld;
    logic signed [SB-1:0] r7_sample;

    assign w_sv = r6_neg ? -r6_y : r6_y;

    always_comb begin
        if (r6_zero) begin
            w_out = '0;
        end else if (w_sv > SAT_HI) begin
            w_out = SAT_HI[SB-1:0];
        end else if (w_sv < SAT_LO) begin
            w_out = SAT_LO[SB-1:0];
        end else begin
            w_out = w_sv[SB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else if (i_en) begin
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_sample <= w_out;
        end
    end

    assign o_valid  = r7_vld;
    assign o_sample = r7_sample;

endmodule

`default_nettype wire

// ===== rtl/core/skc_merge.sv =====
// ----------------------------------------------------------------------------
// skc_merge: joins the two lane results into one output transfer
// An output register and one skid entry decouple the lanes from the receiver;
// the lanes advance as long as the skid entry is free.
// ----------------------------------------------------------------------------
`default_nettype none

module skc_merge #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [SAMPLE_BITS-1:0] i_left,
    input  logic signed [SAMPLE_BITS-1:0] i_right,
    output logic                          o_en,
    skc_out_if.source                     o_smp
);

    logic                          r_ov;
    logic                          r_sv;
    logic signed [SAMPLE_BITS-1:0] r_o_left;
    logic signed [SAMPLE_BITS-1:0] r_o_right;
    logic signed [SAMPLE_BITS-1:0] r_s_left;
    logic signed [SAMPLE_BITS-1:0] r_s_right;
    logic                          n_ov;
    logic                          n_sv;
    logic signed [SAMPLE_BITS-1:0] n_o_left;
    logic signed [SAMPLE_BITS-1:0] n_o_right;
    logic signed [SAMPLE_BITS-1:0] n_s_left;
    logic signed [SAMPLE_BITS-1:0] n_s_right;
    logic                          w_take;
    logic                          w_cap;

    assign w_take = r_ov && o_smp.ready;
    // The lanes only move when the skid entry is empty, so every arriving pair is captured.
    assign w_cap  = !r_sv && i_valid;

    always_comb begin
        n_ov      = r_ov;
        n_sv      = r_sv;
        n_o_left  = r_o_left;
        n_o_right = r_o_right;
        n_s_left  = r_s_left;
        n_s_right = r_s_right;
        if (r_sv) begin
            if (w_take) begin
                n_o_left  = r_s_left;
                n_o_right = r_s_right;
                n_sv      = 1'b0;
            end
        end else if (w_cap) begin
            if (!r_ov || w_take) begin
                n_o_left  = i_left;
                n_o_right = i_right;
                n_ov      = 1'b1;
            end else begin
                n_s_left  = i_left;
                n_s_right = i_right;
                n_sv      = 1'b1;
            end
        end else if (w_take) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            r_ov <= n_ov;
            r_sv <= n_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_left  <= n_o_left;
        r_o_right <= n_o_right;
        r_s_left  <= n_s_left;
        r_s_right <= n_s_right;
    end

    assign o_en            = !r_sv;
    assign o_smp.valid     = r_ov;
    assign o_smp.left_out  = r_o_left;
    assign o_smp.right_out = r_o_right;

endmodule

`default_nettype wire

// ===== rtl/core/stereo_soft_knee_clipper_unit.sv =====
// ----------------------------------------------------------------------------
// stereo_soft_knee_clipper_unit: stereo soft-knee clipper, top level
// Two identical channel lanes, a result merge stage and the register port.
// ----------------------------------------------------------------------------
// Usage:
// i_smp carries one stereo pair plus the saturation amount per transfer, o_smp
// returns the clipped pair; both use valid/ready. The APB port holds the curve
// threshold (byte address 0) and the knee width (byte address 4); write them
// only while no transfer is in flight. pready is always high.
// Throughput is one pair per cycle while the receiver keeps up. Each lane holds
// two restoring dividers (knee square and ratio), which resolve one quotient
// bit per stage; the drive gain takes a single reciprocal multiply stage.
// Reset empties the pipeline and the output buffer and loads the default
// threshold (0.9 x 2^19 LSBs) and knee width (0.2 x 2^19 LSBs).
// When the receiver stalls, the output register holds its pair and one more
// pair lands in a skid entry; the pipeline then freezes and i_smp.ready drops
// until the receiver takes a transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_soft_knee_clipper_unit #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    skc_in_if.sink                       i_smp,
    skc_out_if.source                    o_smp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [skc_pkg::ADDR_W-1:0]   paddr,
    input  logic [skc_pkg::DATA_W-1:0]   pwdata,
    output logic [skc_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    skc_pkg::t_cfg     r_cfg;
    skc_pkg::t_reg_sel w_sel;
    logic              w_wr;
    logic              w_en;
    logic              w_lvalid;
    logic              w_rvalid;
    logic signed [SAMPLE_BITS-1:0] w_left;
    logic signed [SAMPLE_BITS-1:0] w_right;

    // Registers are word aligned; the byte offset bits are ignored.
    assign w_sel  = skc_pkg::t_reg_sel'(paddr[skc_pkg::ADDR_W-1]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{thresh: skc_pkg::THRESH_RST, knee: skc_pkg::KNEE_RST};
        end else if (w_wr) begin
            case (w_sel)
                skc_pkg::REG_THRESH: r_cfg.thresh <= pwdata[skc_pkg::REG_W-1:0];
                skc_pkg::REG_KNEE:   r_cfg.knee   <= pwdata[skc_pkg::REG_W-1:0];
                default:             r_cfg        <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_sel)
            skc_pkg::REG_THRESH: prdata = skc_pkg::DATA_W'(r_cfg.thresh);
            skc_pkg::REG_KNEE:   prdata = skc_pkg::DATA_W'(r_cfg.knee);
            default:             prdata = '0;
        endcase
    end

    assign i_smp.ready = w_en;

    skc_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_left (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_smp.valid),
        .i_sample (i_smp.left_in),
        .i_sat    (i_smp.saturation),
        .i_cfg    (r_cfg),
        .o_valid  (w_lvalid),
        .o_sample (w_left)
    );

    skc_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_right (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_smp.valid),
        .i_sample (i_smp.right_in),
        .i_sat    (i_smp.saturation),
        .i_cfg    (r_cfg),
        .o_valid  (w_rvalid),
        .o_sample (w_right)
    );

    skc_merge #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_lvalid),
        .i_left  (w_left),
        .i_right (w_right),
        .o_en    (w_en),
        .o_smp   (o_smp)
    );

    // Both lanes run in lock step, so their results arrive together.
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_lvalid == w_rvalid)
        else $error("lane results out of step");

    // The skid entry only fills behind a held output pair.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |-> o_smp.valid)
        else $error("skid entry full while output register empty");

    // The pipeline freezes only after the receiver refused a transfer.
    a_freeze_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(w_en) |-> $past(o_smp.valid && !o_smp.ready))
        else $error("pipeline froze without an output stall");

endmodule

`default_nettype wire

// ===== tb/sv/skc_clip_checker.sv =====
// ----------------------------------------------------------------------------
// skc_clip_checker: result checker of the stereo soft-knee clipper
// Watches the input, output and register channels, predicts every clipped
// pair from its own copy of the curve registers, and compares each output
// transfer field by field with the oldest predicted pair.
// ----------------------------------------------------------------------------
module skc_clip_checker #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    skc_in_if                          smp_in,
    skc_out_if                         smp_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic                       pready,
    input  logic [skc_pkg::ADDR_W-1:0] paddr,
    input  logic [skc_pkg::DATA_W-1:0] pwdata,
    output int                         o_pending,
    output int                         o_fail_count
);
    import skc_pkg::*;

    localparam longint SMP_TOP      = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SMP_BOTTOM   = -(longint'(1) <<< (SAMPLE_BITS - 1));
    localparam longint GAIN_ONE_L   = longint'(GAIN_ONE);
    localparam longint RATIO_BASE_L = longint'(RATIO_BASE);
    localparam longint QUAD_BASE_L  = longint'(QUAD_BASE);
    localparam longint RATIO_MUL_L  = longint'(RATIO_MUL);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
    } t_clipped_pair;

    t_clipped_pair    clipped_q[$];
    logic [REG_W-1:0] thresh_shadow;
    logic [REG_W-1:0] knee_shadow;
    int               mismatches = 0;

    assign o_fail_count = mismatches;

    initial o_pending = 0;

    task automatic report_error(input string msg);
        $display("%0t clip check: %s", $time, msg);
        mismatches++;
    endtask

    // Operands are never negative here, so adding half the divisor rounds
    // ties away from zero.
    function automatic longint round_div(input longint num, input longint den);
        return (num + den / 2) / den;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] clip_sample(
        input logic signed [SAMPLE_BITS-1:0] x,
        input logic [SAT_W-1:0]              sat
    );
        longint amt, mag, drv, lvl, kw, dlt, y, ek, sq;
        amt = longint'(sat);
        if (x == '0) return '0;
        mag  = (x < 0) ? -longint'(x) : longint'(x);
        drv  = round_div(mag * (GAIN_ONE_L + amt), GAIN_ONE_L);
        lvl  = longint'(thresh_shadow);
        kw   = (knee_shadow == '0) ? longint'(1) : longint'(knee_shadow);
        dlt  = drv - lvl;
        if (2 * dlt < -kw) begin
            y = drv;
        end else if (2 * dlt > kw) begin
            y = lvl + round_div(dlt * RATIO_MUL_L, amt + RATIO_BASE_L);
        end else begin
            // Inside the knee the offset into it runs from 0 to twice the width.
            ek = 2 * dlt + kw;
            sq = round_div(ek * ek, 8 * kw);
            y  = drv - round_div(sq * (amt + QUAD_BASE_L), amt + RATIO_BASE_L);
        end
        // A negative magnitude from the knee flips the restored sign.
        if (x < 0) y = -y;
        if (y > SMP_TOP) begin
            y = SMP_TOP;
        end else if (y < SMP_BOTTOM) begin
            y = SMP_BOTTOM;
        end
        return y[SAMPLE_BITS-1:0];
    endfunction

    always @(posedge i_clk) begin : monitor
        t_clipped_pair got;
        t_clipped_pair want;
        if (!i_rst_n) begin
            thresh_shadow = THRESH_RST;
            knee_shadow   = KNEE_RST;
            clipped_q.delete();
        end else begin
            if (smp_out.valid && smp_out.ready) begin
                got.left  = smp_out.left_out;
                got.right = smp_out.right_out;
                if (clipped_q.size() == 0) begin
                    report_error($sformatf("output transfer %0d %0d with nothing expected",
                                           got.left, got.right));
                end else begin
                    want = clipped_q.pop_front();
                    if (got.left !== want.left)
                        report_error($sformatf("left_out got %0d expected %0d",
                                               got.left, want.left));
                    if (got.right !== want.right)
                        report_error($sformatf("right_out got %0d expected %0d",
                                               got.right, want.right));
                end
            end
            if (smp_in.valid && smp_in.ready) begin
                want.left  = clip_sample(smp_in.left_in, smp_in.saturation);
                want.right = clip_sample(smp_in.right_in, smp_in.saturation);
                clipped_q.push_back(want);
            end
            if (psel && penable && pwrite && pready) begin
                case (t_reg_sel'(paddr[ADDR_W-1]))
                    REG_THRESH: thresh_shadow = pwdata[REG_W-1:0];
                    REG_KNEE:   knee_shadow   = pwdata[REG_W-1:0];
                    default:    ;
                endcase
            end
        end
        o_pending <= clipped_q.size();
    end

endmodule

// ===== tb/sv/tb_stereo_soft_knee_clipper_unit.sv =====
// ----------------------------------------------------------------------------
// tb_stereo_soft_knee_clipper_unit: testbench of the stereo soft-knee clipper
// Drives stereo pairs through the clipper under several curve settings, from
// directed extremes and knee boundaries to random pairs aimed at the knee,
// with random idling on both channels, a long output stall and full-rate
// stretches. The checker beside the block predicts and compares every pair.
// ----------------------------------------------------------------------------
module tb_stereo_soft_knee_clipper_unit;
    import skc_pkg::*;

    localparam int SAMPLE_BITS  = 24;
    localparam int LATENCY      = 56;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 200000;
    localparam longint GAIN_ONE_L = longint'(GAIN_ONE);

    localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [REG_W-1:0] REG_MAX = {REG_W{1'b1}};

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int               pending;
    int               fail_count;
    int               cycles   = 0;
    int               hold_req = 0;
    bit               tx_idle_on;
    bit               rx_idle_on;
    logic [REG_W-1:0] cur_thresh;
    logic [REG_W-1:0] cur_knee;

    skc_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) smp_in ();
    skc_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) smp_out ();

    stereo_soft_knee_clipper_unit #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_in),
        .o_smp   (smp_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    skc_clip_checker #(.SAMPLE_BITS(SAMPLE_BITS)) clip_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .smp_in       (smp_in),
        .smp_out      (smp_out),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Output side: random idling, plus a long hold-off whenever the stimulus
    // raises a request.
    initial begin : receiver
        int hold_left;
        int hold_done;
        hold_left     = 0;
        hold_done     = 0;
        smp_out.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                smp_out.ready <= 1'b0;
            end else if (hold_left > 0) begin
                smp_out.ready <= 1'b0;
                hold_left--;
            end else if (hold_done != hold_req) begin
                hold_done++;
                hold_left = HOLD_CYCLES - 1;
                smp_out.ready <= 1'b0;
            end else begin
                smp_out.ready <= !(rx_idle_on && $urandom_range(99) < 15);
            end
        end
    end

    task automatic write_reg(input t_reg_sel sel, input logic [DATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({sel, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_pair(input logic signed [SAMPLE_BITS-1:0] left,
                             input logic signed [SAMPLE_BITS-1:0] right,
                             input logic [SAT_W-1:0]              sat);
        while (tx_idle_on && $urandom_range(99) < 15) begin
            smp_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        smp_in.valid      <= 1'b1;
        smp_in.left_in    <= left;
        smp_in.right_in   <= right;
        smp_in.saturation <= sat;
        do @(posedge i_clk); while (!smp_in.ready);
    endtask

    task automatic wait_drained();
        smp_in.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic set_curve(input logic [DATA_W-1:0] thresh_word,
                             input logic [DATA_W-1:0] knee_word);
        wait_drained();
        write_reg(REG_THRESH, thresh_word);
        write_reg(REG_KNEE, knee_word);
        cur_thresh = thresh_word[REG_W-1:0];
        cur_knee   = knee_word[REG_W-1:0];
    endtask

    function automatic logic [SAT_W-1:0] pick_saturation();
        logic [31:0] rnd;
        rnd = $urandom;
        case ($urandom_range(7))
            0:       return rnd[SAT_W-1:0];
            1:       return rnd[0] ? SAT_W'(51200) : '0;
            default: return SAT_W'($urandom_range(51200));
        endcase
    endfunction

    // Half of the magnitudes are aimed so that the driven level lands in or near the
    // knee of the current curve.
    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(
        input logic [SAT_W-1:0] sat
    );
        logic [31:0] rnd;
        longint      mag, centre, span, top;
        rnd = $urandom;
        top = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
        case ($urandom_range(3))
            0: return rnd[SAMPLE_BITS-1:0];
            1: mag = longint'(rnd[9:0]);
            default: begin
                centre = longint'(cur_thresh) * GAIN_ONE_L / (GAIN_ONE_L + longint'(sat));
                span   = longint'(cur_knee) + 16;
                mag    = centre - span + longint'($urandom_range(32'(2 * span)));
            end
        endcase
        if (mag < 0) mag = 0;
        if (mag > top) mag = top;
        if (rnd[31]) mag = -mag;
        return mag[SAMPLE_BITS-1:0];
    endfunction

    task automatic send_random(input int count);
        logic [SAT_W-1:0] sat;
        repeat (count) begin
            sat = pick_saturation();
            send_pair(pick_sample(sat), pick_sample(sat), sat);
        end
    endtask

    initial begin : stimulus
        logic signed [SAMPLE_BITS-1:0] t0;
        logic signed [SAMPLE_BITS-1:0] half_k;
        t0                = SAMPLE_BITS'(THRESH_RST);
        half_k            = SAMPLE_BITS'(KNEE_RST / 2);
        smp_in.valid      = 1'b0;
        smp_in.left_in    = '0;
        smp_in.right_in   = '0;
        smp_in.saturation = '0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        tx_idle_on        = 1'b1;
        rx_idle_on        = 1'b1;
        cur_thresh        = THRESH_RST;
        cur_knee          = KNEE_RST;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default curve: zero, full scale, drive extremes and the knee edges.
        send_pair('0, '0, '0);
        send_pair(SMP_MAX, SMP_MIN, '0);
        send_pair(SMP_MAX, SMP_MIN, SAT_W'(51200));
        send_pair(SMP_MIN, SMP_MAX, SAT_W'(65535));
        send_pair(SAMPLE_BITS'(1), -SAMPLE_BITS'(1), '0);
        send_pair(t0, -t0, '0);
        send_pair(t0 - half_k, -(t0 + half_k), '0);
        send_pair(t0 - half_k - 1, t0 + half_k + 1, '0);
        send_pair(t0, -(t0 / 2), SAT_W'(25600));

        // No threshold and the widest knee, where the knee overshoots zero.
        set_curve('0, DATA_W'(REG_MAX));
        send_pair(SAMPLE_BITS'(1), -SAMPLE_BITS'(1), '0);
        send_pair(SAMPLE_BITS'(1000), -SAMPLE_BITS'(1000), SAT_W'(25600));
        send_pair(SMP_MAX, SMP_MIN, SAT_W'(65535));
        send_pair(SAMPLE_BITS'(300000), -SAMPLE_BITS'(2), SAT_W'(51200));
        send_random(90);

        // Top threshold and the narrowest knee; full drive runs out of range.
        set_curve(DATA_W'(REG_MAX), DATA_W'(1));
        send_pair(SMP_MAX, SMP_MIN, SAT_W'(65535));
        send_pair(SMP_MAX, SMP_MIN, '0);
        send_pair(-SAMPLE_BITS'(3), SAMPLE_BITS'(5000000), SAT_W'(40000));
        send_random(90);

        // A knee width of zero behaves as one LSB; the upper data bits are junk.
        set_curve({9'h1A5, 23'd300000}, {9'h1FF, 23'd0});
        send_pair(SAMPLE_BITS'(300000), -SAMPLE_BITS'(300000), '0);
        send_pair(SAMPLE_BITS'(300001), -SAMPLE_BITS'(299999), '0);
        send_random(90);

        // Back to the reset curve: a long output stall fills the pipeline and
        // stalls the input while pairs keep being offered.
        set_curve(DATA_W'(THRESH_RST), DATA_W'(KNEE_RST));
        hold_req++;
        send_random(200);
        wait_drained();

        // Full rate on both sides.
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_random(150);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;

        repeat (3) begin
            set_curve(DATA_W'($urandom_range(32'(REG_MAX))),
                      DATA_W'($urandom_range(200000, 1)));
            send_random(100);
        end

        wait_drained();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
